// ===== sv/hfb_pkg.sv =====
// Package for the 2-D byte Haar transform block: sizes, register indexes,
// the buffered group record and the small arithmetic helpers.
// No dependencies; hfb_out_if, hfb_ctrl, hfb_out and the top level import it.
package hfb_pkg;

  localparam int STRIDE_MAX = 4096;
  localparam int ROWS_MAX   = 4096;
  localparam int STRIDE_LIM = STRIDE_MAX & ~3;

  localparam int CNT_W      = 12;
  localparam int DIM_W      = 13;
  localparam int RAW_W      = 14;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int PAIR_DEPTH = STRIDE_MAX / 2;
  localparam int ADDR_W     = $clog2(PAIR_DEPTH);
  localparam int PAIR_W     = 16;
  localparam int ARITH_W    = 11;

  localparam logic signed [ARITH_W-1:0] COEFF_BIAS = 11'sd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic signed [ARITH_W-1:0] arith_t;

  // One pending 2x2 group. When from_ram is set the top pair comes from the
  // row memory and a0/a1 form the bottom pair; otherwise a0/a1 are the top
  // pair and the bottom pair is zero.
  typedef struct packed {
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             from_ram;
    logic [CNT_W-1:0] row_lo;
    logic [CNT_W-1:0] row_hi;
    logic [CNT_W-1:0] col_lo;
    logic [CNT_W-1:0] col_hi;
    logic             frame_end;
  } group_t;

  // Signed division by 2**sh, truncating toward zero.
  function automatic arith_t div_trunc(input arith_t x, input int unsigned sh);
    arith_t mag;
    arith_t q;
    mag = (x < 0) ? -x : x;
    q   = mag >>> sh;
    return (x < 0) ? -q : q;
  endfunction

  function automatic logic [7:0] to_coeff_byte(input arith_t v);
    arith_t biased;
    biased = v + COEFF_BIAS;
    return biased[7:0];
  endfunction

  function automatic arith_t widen(input logic [7:0] b);
    return $signed({3'b000, b});
  endfunction

endpackage

// ===== sv/hfb_in_if.sv =====
// Input channel of the Haar block: one image byte per item.
// Depends on nothing but the handshake convention valid/ready.
interface hfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== sv/hfb_out_if.sv =====
// Output channel of the Haar block: one coefficient with its frame position.
// Depends on hfb_pkg for the position width.
interface hfb_out_if;
  import hfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       coeff_byte;
  logic [CNT_W-1:0] out_row;
  logic [CNT_W-1:0] out_col;
  logic             group_last;
  logic             frame_last;

  modport source (output valid, output coeff_byte, output out_row, output out_col,
                  output group_last, output frame_last, input ready);
  modport sink   (input valid, input coeff_byte, input out_row, input out_col,
                  input group_last, input frame_last, output ready);
endinterface

// ===== sv/hfb_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module hfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/hfb_ctrl.sv =====
// Input side of the Haar block: configuration, raster counters, held byte,
// row memory addressing and the one-group stage that waits for the read.
// Depends on hfb_pkg and hfb_in_if.
module hfb_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfb_pkg::CFG_DATA_W-1:0] cfg_data,
  hfb_in_if.sink                       pixel_ch,
  input  logic                         grp_pop,
  output logic                         grp_valid,
  output hfb_pkg::group_t              grp,
  output logic                         ram_we,
  output logic                         ram_re,
  output logic [hfb_pkg::ADDR_W-1:0]   ram_addr,
  output logic [hfb_pkg::PAIR_W-1:0]   ram_wdata
);
  import hfb_pkg::*;

  logic [WIDTH_W-1:0]  width_pixels;
  logic [HEIGHT_W-1:0] height_rows;
  logic [CNT_W-1:0]    col_count;
  logic [CNT_W-1:0]    row_count;
  logic [7:0]          held_byte;

  logic [WIDTH_W-1:0]  w_eff;
  logic [RAW_W-1:0]    stride_raw;
  logic [DIM_W-1:0]    stride;
  logic [DIM_W-1:0]    height_eff;
  logic [DIM_W-1:0]    col_inc;
  logic [DIM_W-1:0]    row_inc;
  logic                last_row;
  logic                last_col;
  logic                accept;
  logic                emit;
  logic [CNT_W-1:0]    half_rows;
  logic [CNT_W-1:0]    half_stride;
  group_t              grp_next;

  always_comb begin
    w_eff      = (width_pixels == '0) ? WIDTH_W'(1) : width_pixels;
    stride_raw = (RAW_W'(w_eff) * RAW_W'(3) + RAW_W'(3)) & ~RAW_W'(3);
    stride     = (stride_raw > RAW_W'(STRIDE_LIM)) ? DIM_W'(STRIDE_LIM)
                                                    : stride_raw[DIM_W-1:0];
    if (height_rows == '0) begin
      height_eff = DIM_W'(1);
    end else if (height_rows > HEIGHT_W'(ROWS_MAX)) begin
      height_eff = DIM_W'(ROWS_MAX);
    end else begin
      height_eff = height_rows;
    end
    half_rows   = CNT_W'((height_eff + DIM_W'(1)) >> 1);
    half_stride = CNT_W'(stride >> 1);

    col_inc  = {1'b0, col_count} + DIM_W'(1);
    row_inc  = {1'b0, row_count} + DIM_W'(1);
    last_row = ({1'b0, row_count} == height_eff - DIM_W'(1));
    last_col = ({1'b0, col_count} == stride - DIM_W'(1));

    pixel_ch.ready = !grp_valid || grp_pop;
    accept         = pixel_ch.valid && pixel_ch.ready;
    emit           = col_count[0] && (row_count[0] || last_row);

    ram_addr  = col_count[CNT_W-1:1];
    ram_wdata = {held_byte, pixel_ch.data_byte};
    ram_we    = accept && !row_count[0] && col_count[0];
    ram_re    = accept && row_count[0] && col_count[0];

    grp_next.a0        = held_byte;
    grp_next.a1        = pixel_ch.data_byte;
    grp_next.from_ram  = row_count[0];
    grp_next.row_lo    = row_count >> 1;
    grp_next.row_hi    = (row_count >> 1) + half_rows;
    grp_next.col_lo    = col_count >> 1;
    grp_next.col_hi    = (col_count >> 1) + half_stride;
    grp_next.frame_end = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_pixels <= WIDTH_W'(640);
      height_rows  <= HEIGHT_W'(480);
      col_count    <= '0;
      row_count    <= '0;
      held_byte    <= '0;
      grp_valid    <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
        if (cfg_index == REG_WIDTH) begin
          width_pixels <= cfg_data[WIDTH_W-1:0];
        end else begin
          height_rows <= cfg_data[HEIGHT_W-1:0];
        end
        col_count <= '0;
        row_count <= '0;
      end else if (accept) begin
        if (col_inc >= stride) begin
          col_count <= '0;
          row_count <= (row_inc >= height_eff) ? '0 : row_inc[CNT_W-1:0];
        end else begin
          col_count <= col_inc[CNT_W-1:0];
        end
      end
      if (accept && !col_count[0]) begin
        held_byte <= pixel_ch.data_byte;
      end
      if (accept && emit) begin
        grp_valid <= 1'b1;
      end else if (grp_pop) begin
        grp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      grp <= grp_next;
    end
  end

  // The column counter never reaches the stride.
  assert property (@(posedge clk) disable iff (rst) {1'b0, col_count} < stride)
    else $error("column counter beyond stride");

  // The row counter never reaches the effective height.
  assert property (@(posedge clk) disable iff (rst) {1'b0, row_count} < height_eff)
    else $error("row counter beyond height");

  // A waiting group is not lost or overwritten before it is taken.
  assert property (@(posedge clk) disable iff (rst)
                   grp_valid && !grp_pop |=> grp_valid && $stable(grp))
    else $error("pending group lost");

endmodule

// ===== sv/hfb_out.sv =====
// Output side of the Haar block: the 2x2 arithmetic and a four-beat buffer
// that sends LL, LH, HL and HH in turn. Depends on hfb_pkg and hfb_out_if.
module hfb_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       grp_valid,
  input  hfb_pkg::group_t            grp,
  input  logic [hfb_pkg::PAIR_W-1:0] ram_rdata,
  output logic                       grp_pop,
  hfb_out_if.source                  coeff_ch
);
  import hfb_pkg::*;

  arith_t t0, t1, b0, b1;
  arith_t s0, s1, d0, d1;
  logic [7:0] coeff_next [4];

  logic [7:0]       coeff [4];
  logic [CNT_W-1:0] row_lo, row_hi, col_lo, col_hi;
  logic             frame_end;
  logic [1:0]       beat;
  logic             busy;
  logic             take;
  logic             last_beat;

  always_comb begin
    if (grp.from_ram) begin
      t0 = widen(ram_rdata[15:8]);
      t1 = widen(ram_rdata[7:0]);
      b0 = widen(grp.a0);
      b1 = widen(grp.a1);
    end else begin
      t0 = widen(grp.a0);
      t1 = widen(grp.a1);
      b0 = '0;
      b1 = '0;
    end
    s0 = div_trunc(t0 + b0, 2);
    d0 = div_trunc(t0 - b0, 2);
    s1 = div_trunc(t1 + b1, 2);
    d1 = div_trunc(t1 - b1, 2);
    coeff_next[0] = to_coeff_byte(div_trunc(s0 + s1, 1));
    coeff_next[1] = to_coeff_byte(div_trunc(s0 - s1, 1));
    coeff_next[2] = to_coeff_byte(div_trunc(d0 + d1, 1));
    coeff_next[3] = to_coeff_byte(div_trunc(d0 - d1, 1));

    take      = busy && coeff_ch.ready;
    last_beat = (beat == 2'd3);
    grp_pop   = grp_valid && (!busy || (take && last_beat));

    coeff_ch.valid      = busy;
    coeff_ch.coeff_byte = coeff[beat];
    coeff_ch.out_row    = beat[1] ? row_hi : row_lo;
    coeff_ch.out_col    = beat[0] ? col_hi : col_lo;
    coeff_ch.group_last = last_beat;
    coeff_ch.frame_last = last_beat && frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (grp_pop) begin
      busy <= 1'b1;
      beat <= '0;
    end else if (take) begin
      beat <= beat + 2'd1;
      if (last_beat) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_pop) begin
      coeff     <= coeff_next;
      row_lo    <= grp.row_lo;
      row_hi    <= grp.row_hi;
      col_lo    <= grp.col_lo;
      col_hi    <= grp.col_hi;
      frame_end <= grp.frame_end;
    end
  end

  // A stalled coefficient keeps its place in the group.
  assert property (@(posedge clk) disable iff (rst)
                   busy && !coeff_ch.ready |=> busy && $stable(beat))
    else $error("beat advanced while stalled");

  // A new group is only loaded into a free or draining buffer.
  assert property (@(posedge clk) disable iff (rst)
                   grp_pop && busy |-> last_beat && coeff_ch.ready)
    else $error("group loaded over a busy buffer");

  // The end of the frame is always the end of a group.
  assert property (@(posedge clk) disable iff (rst)
                   coeff_ch.valid && coeff_ch.frame_last |-> coeff_ch.group_last)
    else $error("frame end inside a group");

endmodule

// ===== sv/haar_forward_2d_bytes_core.sv =====
// Top level of the single-level 2-D Haar transform over image bytes.
// Depends on hfb_pkg, hfb_in_if, hfb_out_if, hfb_ram, hfb_ctrl and hfb_out.
//
// Usage. Bytes of a 24-bit image enter on pixel_ch in raster order, padding
// included, each row being a stride of three bytes per pixel rounded up to
// four. Coefficients leave on coeff_ch, each item carrying the coefficient
// plus 64 in its low eight bits, its row and column in the quadrant layout,
// a flag on the fourth item of each 2x2 group and a flag on the last item of
// the frame. Width and height are set through cfg_we/cfg_index/cfg_data
// while the block is idle; a write to a known register restarts the frame.
//
// The even row is kept as byte pairs in a 2048 x 16 single-port memory.
// On an odd row the pair above is read when the odd-column byte is taken,
// and the read data and the group are registered together; the first
// coefficient shows once the group is loaded into the output buffer. Each
// group is sent as four items, one per cycle while coeff_ch is ready, so the
// output port sets the sustained rate on group rows. A completed group waits
// in a four-beat buffer while the next group is formed, and one further
// group may wait for it; input is held off only then. Reset loads width 640
// and height 480 and starts a new frame; the memory needs no clearing, as
// each pair is written on the even row before the odd row reads it.
module haar_forward_2d_bytes_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [hfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hfb_pkg::CFG_DATA_W-1:0] cfg_data,
  hfb_in_if.sink                       pixel_ch,
  hfb_out_if.source                    coeff_ch
);
  import hfb_pkg::*;

  logic               grp_valid;
  logic               grp_pop;
  group_t             grp;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_addr;
  logic [PAIR_W-1:0]  ram_wdata;
  logic [PAIR_W-1:0]  ram_rdata;

  // Counters, configuration and the stage that waits for the row memory.
  hfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_ch  (pixel_ch),
    .grp_pop   (grp_pop),
    .grp_valid (grp_valid),
    .grp       (grp),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata)
  );

  // The kept row, stored as even/odd byte pairs.
  hfb_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (PAIR_DEPTH)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Arithmetic of the group and serialisation into four items.
  hfb_out u_out (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .ram_rdata (ram_rdata),
    .grp_pop   (grp_pop),
    .coeff_ch  (coeff_ch)
  );

endmodule
